// File: rtl/rpn_pkg.sv
// shared types and constants for the rpn stack calculator
`default_nettype none

package rpn_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int DEPTH_W   = 5;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_POP  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNDER   = 2'd1,
        ST_OVER    = 2'd2,
        ST_DIVZERO = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TOP_CUR     = 2'd0,
        TOP_ZERO    = 2'd1,
        TOP_OPERAND = 2'd2,
        TOP_RESULT  = 2'd3
    } top_sel_t;

    typedef enum logic [1:0] {
        SP_HOLD = 2'd0,
        SP_INC  = 2'd1,
        SP_DEC  = 2'd2
    } sp_act_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_FETCH  = 3'd1,
        S_EXEC   = 3'd2,
        S_DIV    = 3'd3,
        S_COMMIT = 3'd4
    } state_t;

    typedef struct packed {
        logic     load;
        logic     fetch;
        logic     alu_load;
        logic     div_start;
        logic     respond;
        status_t  status;
        top_sel_t top_sel;
        sp_act_t  sp_act;
        logic     wr_push;
        logic     wr_result;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic sp_zero;
        logic sp_lt2;
        logic sp_full;
        logic b_zero;
        logic div_busy;
    } stat_t;

endpackage

`default_nettype wire

// File: rtl/rpn_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
`default_nettype none

module rpn_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [rpn_pkg::DATA_W-1:0] dividend,
    input  wire logic [rpn_pkg::DATA_W-1:0] divisor,
    output logic                            busy,
    output logic [rpn_pkg::DATA_W-1:0]      quotient
);
    import rpn_pkg::*;

    logic                busy_reg, busy_next;
    logic [DIV_CW-1:0]   cnt_reg, cnt_next;
    logic [DATA_W-1:0]   rem_reg, quo_reg, dvs_reg;
    logic                neg_reg;
    logic [DATA_W-1:0]   mag_a, mag_b;
    logic [DATA_W:0]     shifted, diff;

    assign mag_a   = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
    assign mag_b   = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - DIV_CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= mag_a;
            dvs_reg <= mag_b;
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_reg <= diff[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

`default_nettype wire

// File: rtl/rpn_dpath.sv
// datapath: operand stack memory, stack pointer, alu, divider and result registers
`default_nettype none

module rpn_dpath #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rpn_pkg::cmd_t               cmd,
    output rpn_pkg::stat_t                   stat,
    input  wire logic [rpn_pkg::OP_W-1:0]    op,
    input  wire logic signed [rpn_pkg::DATA_W-1:0] operand,
    output logic                             done,
    output logic signed [rpn_pkg::DATA_W-1:0] top_value,
    output logic [rpn_pkg::DEPTH_W-1:0]      stack_depth,
    output logic [1:0]                       status
);
    import rpn_pkg::*;

    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    logic [PW-1:0]     sp_reg, sp_next;
    logic              done_reg;
    op_t               op_reg;
    logic [DATA_W-1:0] operand_reg, a_reg, b_reg, alu_reg, top_value_reg;
    status_t           status_reg;

    logic [PW-1:0]     sp_m1, sp_m2;
    logic [DATA_W-1:0] div_q, result, cur_top, top_sel_val, wr_data;
    logic [DATA_W*2-1:0] product;
    logic [AW-1:0]     wr_addr;
    logic              wr_en, div_busy;
    logic [PW+DEPTH_W-1:0] sp_ext;

    assign sp_m1 = sp_reg - PW'(1);
    assign sp_m2 = sp_reg - PW'(2);

    rpn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (a_reg),
        .divisor  (b_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign product = a_reg * b_reg;
    assign result  = (op_reg == OP_DIV) ? div_q : alu_reg;
    assign cur_top = (sp_reg == '0) ? '0 : b_reg;

    always_comb
    begin
        unique case (cmd.top_sel)
            TOP_CUR:     top_sel_val = cur_top;
            TOP_ZERO:    top_sel_val = '0;
            TOP_OPERAND: top_sel_val = operand_reg;
            TOP_RESULT:  top_sel_val = result;
            default:     top_sel_val = cur_top;
        endcase
    end

    assign wr_en   = cmd.wr_push | cmd.wr_result;
    assign wr_addr = cmd.wr_push ? sp_reg[AW-1:0] : sp_m2[AW-1:0];
    assign wr_data = cmd.wr_push ? operand_reg : result;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.fetch)
        begin
            b_reg <= mem[sp_m1[AW-1:0]];
            a_reg <= mem[sp_m2[AW-1:0]];
        end
    end

    always_comb
    begin
        case (cmd.sp_act)
            SP_INC:  sp_next = sp_reg + PW'(1);
            SP_DEC:  sp_next = sp_m1;
            default: sp_next = sp_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            sp_reg   <= sp_next;
            done_reg <= cmd.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op_t'(op);
            operand_reg <= operand;
        end
        if (cmd.alu_load)
        begin
            case (op_reg)
                OP_SUB:  alu_reg <= a_reg - b_reg;
                OP_MUL:  alu_reg <= product[DATA_W-1:0];
                default: alu_reg <= a_reg + b_reg;
            endcase
        end
        if (cmd.respond)
        begin
            top_value_reg <= top_sel_val;
            status_reg    <= cmd.status;
        end
    end

    assign stat.op       = op_reg;
    assign stat.sp_zero  = (sp_reg == '0);
    assign stat.sp_lt2   = (sp_reg < PW'(2));
    assign stat.sp_full  = (sp_reg == PW'(STACK_DEPTH));
    assign stat.b_zero   = (b_reg == '0);
    assign stat.div_busy = div_busy;

    assign sp_ext      = {{DEPTH_W{1'b0}}, sp_reg};
    assign done        = done_reg;
    assign top_value   = top_value_reg;
    assign stack_depth = sp_ext[DEPTH_W-1:0];
    assign status      = status_reg;

endmodule

`default_nettype wire

// File: rtl/rpn_ctrl.sv
// controller state machine sequencing fetch, execute, divide and commit
`default_nettype none

module rpn_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire rpn_pkg::stat_t stat,
    output rpn_pkg::cmd_t       cmd,
    output logic                busy
);
    import rpn_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.alu_load = 1'b1;
                if (stat.op == OP_DIV && !stat.sp_lt2 && !stat.b_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.respond = 1'b1;
                cmd.status  = ST_OK;
                cmd.top_sel = TOP_CUR;
                cmd.sp_act  = SP_HOLD;
                unique case (stat.op) inside
                    OP_PUSH:
                    begin
                        if (stat.sp_full)
                        begin
                            cmd.status = ST_OVER;
                        end
                        else
                        begin
                            cmd.wr_push = 1'b1;
                            cmd.sp_act  = SP_INC;
                            cmd.top_sel = TOP_OPERAND;
                        end
                    end
                    OP_POP:
                    begin
                        if (stat.sp_zero)
                        begin
                            cmd.status  = ST_UNDER;
                            cmd.top_sel = TOP_ZERO;
                        end
                        else
                        begin
                            cmd.sp_act = SP_DEC;
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV:
                    begin
                        if (stat.sp_lt2)
                        begin
                            cmd.status = ST_UNDER;
                        end
                        else if (stat.op == OP_DIV && stat.b_zero)
                        begin
                            cmd.status = ST_DIVZERO;
                        end
                        else
                        begin
                            cmd.wr_result = 1'b1;
                            cmd.sp_act    = SP_DEC;
                            cmd.top_sel   = TOP_RESULT;
                        end
                    end
                    default:
                    begin
                        cmd.status = ST_OK;
                    end
                endcase
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/rpn_stack_calculator_unit.sv
// top level of the rpn stack calculator: controller plus datapath
`default_nettype none

// Evaluates reverse Polish integer expressions on a stack of STACK_DEPTH
// 32-bit entries. A request is taken when start is high and busy is low; its
// single result appears for one cycle on top_value, stack_depth and status
// with done high, and cannot be held off. Push, pop, add, subtract, multiply,
// undefined op codes and every faulting request pass through fetch, execute
// and commit states; a divide also waits in a divide state for the restoring
// divider that retires one quotient bit per cycle. The result strobe shows in
// the idle cycle, so the next request may be accepted while done is high.
// Faults (underflow, overflow, divide by zero) leave the stack unchanged.
module rpn_stack_calculator_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [rpn_pkg::OP_W-1:0]           op,
    input  wire logic signed [rpn_pkg::DATA_W-1:0]  operand,
    output logic                                    done,
    output logic signed [rpn_pkg::DATA_W-1:0]       top_value,
    output logic [rpn_pkg::DEPTH_W-1:0]             stack_depth,
    output logic [1:0]                              status
);
    import rpn_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    rpn_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    rpn_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .op          (op),
        .operand     (operand),
        .done        (done),
        .top_value   (top_value),
        .stack_depth (stack_depth),
        .status      (status)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted request did not start work");

    a_over_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_OVER |-> stack_depth == DEPTH_W'(STACK_DEPTH))
        else $error("overflow reported on a stack that is not full");

    a_divzero_top: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_DIVZERO |-> top_value == '0 && stack_depth >= DEPTH_W'(2))
        else $error("divide by zero with a nonzero divisor or short stack");

endmodule

`default_nettype wire

// File: dv/rpn_stack_calculator_unit_test.sv
// self-checking testbench for the rpn stack calculator unit
`default_nettype none

module rpn_stack_calculator_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rpn_pkg::*;

    localparam int STACK_DEPTH = 16;
    localparam int IDLE_LIMIT  = 2000;
    localparam logic [OP_W-1:0]   OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0]   OP_RSVD7 = 3'd7;
    localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MOST_POS = 32'h7FFF_FFFF;

    typedef struct {
        logic [DATA_W-1:0]  top;
        logic [DEPTH_W-1:0] depth;
        status_t            status;
    } calc_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [OP_W-1:0]          op = '0;
    logic signed [DATA_W-1:0] operand = '0;
    logic                     busy;
    logic                     done;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       stack_depth;
    logic [1:0]               status;

    logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
    int                calc_sp = 0;
    calc_result_t      pending_results [$];
    int                errors = 0;
    int                idle_cycles = 0;

    rpn_stack_calculator_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .operand(operand),
        .done(done),
        .top_value(top_value),
        .stack_depth(stack_depth),
        .status(status)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic calc_result_t apply_request(input logic [OP_W-1:0] code,
                                                   input logic [DATA_W-1:0] value);
        calc_result_t      res;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        logic [DATA_W-1:0] quo;
        res.top    = (calc_sp == 0) ? '0 : calc_stack[calc_sp-1];
        res.status = ST_OK;
        case (code) inside
            OP_PUSH:
            begin
                if (calc_sp >= STACK_DEPTH)
                    res.status = ST_OVER;
                else
                begin
                    calc_stack[calc_sp] = value;
                    calc_sp++;
                    res.top = value;
                end
            end
            OP_POP:
            begin
                if (calc_sp == 0)
                begin
                    res.status = ST_UNDER;
                    res.top    = '0;
                end
                else
                    calc_sp--;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV:
            begin
                if (calc_sp < 2)
                    res.status = ST_UNDER;
                else
                begin
                    b = calc_stack[calc_sp-1];
                    a = calc_stack[calc_sp-2];
                    if (code == OP_DIV && b == '0)
                        res.status = ST_DIVZERO;
                    else
                    begin
                        case (code)
                            OP_ADD: res.top = a + b;
                            OP_SUB: res.top = a - b;
                            OP_MUL: res.top = a * b;
                            default:
                            begin
                                // truncate toward zero on magnitudes
                                mag_a   = a[DATA_W-1] ? -a : a;
                                mag_b   = b[DATA_W-1] ? -b : b;
                                quo     = mag_a / mag_b;
                                res.top = (a[DATA_W-1] ^ b[DATA_W-1]) ? -quo : quo;
                            end
                        endcase
                        calc_sp--;
                        calc_stack[calc_sp-1] = res.top;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.depth = calc_sp[DEPTH_W-1:0];
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return 32'd1;
            2: return '1;
            3: return MOST_NEG;
            4: return MOST_POS;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] value);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        op      <= code;
        operand <= value;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        pending_results.push_back(apply_request(code, value));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_push_pop();
        send_request(OP_PUSH, MOST_POS);
        send_request(OP_PUSH, MOST_NEG);
        send_request(OP_POP, $urandom);
        send_request(OP_POP, $urandom);
        send_request(OP_POP, $urandom);
    endtask

    task automatic test_underflow_and_reserved();
        send_request(OP_ADD, $urandom);
        send_request(OP_RSVD7, $urandom);
        send_request(OP_PUSH, 32'd5);
        send_request(OP_DIV, $urandom);
        send_request(OP_RSVD6, $urandom);
        send_request(OP_POP, $urandom);
    endtask

    task automatic test_arithmetic();
        send_request(OP_PUSH, MOST_POS);
        send_request(OP_PUSH, 32'd1);
        send_request(OP_ADD, $urandom);
        send_request(OP_PUSH, 32'd1);
        send_request(OP_SUB, $urandom);
        send_request(OP_PUSH, '0);
        send_request(OP_DIV, $urandom);
        send_request(OP_POP, $urandom);
        send_request(OP_PUSH, MOST_NEG);
        send_request(OP_MUL, $urandom);
        send_request(OP_PUSH, MOST_NEG);
        send_request(OP_PUSH, '1);
        send_request(OP_DIV, $urandom);
        send_request(OP_PUSH, -32'sd7);
        send_request(OP_PUSH, 32'd2);
        send_request(OP_DIV, $urandom);
    endtask

    // stack alternates between growing toward full and shrinking toward empty
    task automatic test_random_expressions(input int count);
        bit              growing;
        logic [OP_W-1:0] code;
        growing = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            if (i % 75 == 74)
                wait_drained();
            if (growing && calc_sp == STACK_DEPTH && $urandom_range(0, 2) != 0)
                growing = 1'b0;
            else if (!growing && calc_sp < 2 && $urandom_range(0, 2) != 0)
                growing = 1'b1;
            else if ($urandom_range(0, 19) == 0)
                growing = !growing;
            if ($urandom_range(0, 31) == 0)
                code = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
            else if (growing == ($urandom_range(0, 4) != 0))
                code = OP_PUSH;
            else
            begin
                case ($urandom_range(0, 5))
                    0: code = OP_POP;
                    1: code = OP_ADD;
                    2: code = OP_SUB;
                    3: code = OP_MUL;
                    default: code = OP_DIV;
                endcase
            end
            send_request(code, pick_operand());
        end
    endtask

    always @(negedge clk)
    begin
        calc_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: top_value %0h", top_value);
                errors++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (top_value !== exp_res.top)
                begin
                    $error("top_value mismatch: expected %0h, actual %0h", exp_res.top, top_value);
                    errors++;
                end
                if (stack_depth !== exp_res.depth)
                begin
                    $error("stack_depth mismatch: expected %0d, actual %0d",
                           exp_res.depth, stack_depth);
                    errors++;
                end
                if (status !== exp_res.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("rpn_stack_calculator_unit_test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_push_pop();
        test_underflow_and_reserved();
        test_arithmetic();
        wait_drained();
        test_random_expressions(450);
        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("rpn_stack_calculator_unit_test passed");
        else
            $display("rpn_stack_calculator_unit_test failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: rpn_stack_calculator_unit.f
rtl/rpn_pkg.sv
rtl/rpn_div.sv
rtl/rpn_dpath.sv
rtl/rpn_ctrl.sv
rtl/rpn_stack_calculator_unit.sv
dv/rpn_stack_calculator_unit_test.sv
